>>> hw/rtl/ukf_pkg.sv
// Shared constants, status codes and controller/datapath interface types for the unique key FIFO.
package ukf_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_WIDTH_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Request kind carried in s_tuser
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    typedef struct packed {
        logic load;     // capture the incoming transaction
        logic scan;     // step the duplicate key scan
        logic read;     // fetch the head entry
        logic commit;   // update the queue and register the result
    } ukf_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } ukf_stat_t;

endpackage

>>> hw/rtl/ukf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ukf_ram
    import ukf_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ukf_ctrl.sv
// Controller state machine sequencing accept, key scan, head read and commit.
module ukf_ctrl
    import ukf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tuser,
    input  ukf_stat_t stat,
    output ukf_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_READ   = 4'b0100,
        S_COMMIT = 4'b1000
    } ukf_state_t;

    ukf_state_t state_reg;
    ukf_state_t state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (stat.empty)
                    begin
                        state_next = S_COMMIT;
                    end
                    else if (s_tuser == REQ_DEQUEUE)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/ukf_dpath.sv
// Datapath: ring pointers, entry count, key and data stores, scan compare, result register.
module ukf_dpath
    import ukf_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int OCC_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((OCC_W + KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ukf_cmd_t            cmd,
    output ukf_stat_t           stat,
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0] m_tuser
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = OCC_W + 1;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic                  req_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    logic [PTR_W-1:0]      head_reg,  head_next;
    logic [PTR_W-1:0]      tail_reg,  tail_next;
    logic [OCC_W-1:0]      count_reg, count_next;
    logic [OCC_W-1:0]      issue_reg, issue_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  cmp_last_reg,  cmp_last_next;
    logic                  dup_reg,       dup_next;
    logic                  out_valid_reg, out_valid_next;

    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [OCC_W-1:0]      out_occ_reg,    out_occ_next;
    logic [KEY_WIDTH-1:0]  out_key_reg,    out_key_next;
    logic [DATA_WIDTH-1:0] out_data_reg,   out_data_next;

    logic                  scan_rd;
    logic [PTR_W-1:0]      scan_addr;
    logic                  key_rd_en;
    logic [PTR_W-1:0]      key_rd_addr;
    logic [KEY_WIDTH-1:0]  key_rd_data;
    logic [DATA_WIDTH-1:0] data_rd_data;
    logic                  wr_en;
    logic                  hit;
    logic                  full;

    assign full      = (count_reg == OCC_W'(DEPTH));
    assign scan_rd   = cmd.scan && (issue_reg < count_reg);
    assign scan_addr = ring_add(head_reg, issue_reg);
    assign key_rd_en   = scan_rd || cmd.read;
    assign key_rd_addr = cmd.read ? head_reg : scan_addr;
    assign hit         = cmp_valid_reg && (key_rd_data == key_reg);

    assign stat.empty     = (count_reg == '0);
    assign stat.scan_hit  = hit;
    assign stat.scan_last = cmp_valid_reg && cmp_last_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    ukf_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    ukf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (data_reg),
        .rd_en   (cmd.read),
        .rd_addr (head_reg),
        .rd_data (data_rd_data)
    );

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = 1'b0;
        dup_next        = dup_reg;
        wr_en           = 1'b0;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        out_key_next    = out_key_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (cmd.load)
        begin
            issue_next = '0;
            dup_next   = 1'b0;
        end

        // issue one key read per cycle, compare it the cycle after
        if (scan_rd)
        begin
            issue_next     = issue_reg + OCC_W'(1);
            cmp_valid_next = 1'b1;
            cmp_last_next  = ((issue_reg + OCC_W'(1)) == count_reg);
        end
        if (cmd.scan && hit)
        begin
            dup_next = 1'b1;
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_key_next   = '0;
            out_data_next  = '0;
            if (req_reg == REQ_ENQUEUE)
            begin
                if (dup_reg)
                begin
                    out_status_next = ST_DUPLICATE;
                end
                else if (full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    tail_next       = ring_add(tail_reg, OCC_W'(1));
                    count_next      = count_reg + OCC_W'(1);
                    out_status_next = ST_ENQUEUED;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    head_next       = ring_add(head_reg, OCC_W'(1));
                    count_next      = count_reg - OCC_W'(1);
                    out_status_next = ST_DEQUEUED;
                    out_key_next    = key_rd_data;
                    out_data_next   = data_rd_data;
                end
            end
            out_occ_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            dup_reg       <= dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= s_tuser;
            key_reg  <= s_tdata[KEY_WIDTH-1:0];
            data_reg <= s_tdata[KEY_WIDTH +: DATA_WIDTH];
        end
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
        out_key_reg    <= out_key_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'({out_data_reg, out_key_reg, out_occ_reg});

endmodule

>>> hw/rtl/unique_key_fifo_unit.sv
// Top level of the unique key FIFO: controller and datapath joined by command and status.
//
// A queue of key/data pairs that refuses an enqueue whose key matches a held entry.
// Slave channel: one transaction per request; s_tuser selects enqueue (0) or dequeue (1),
// s_tdata carries the key and data to enqueue.
// Master channel: one transaction per request; m_tuser is the status code
// (enqueued, duplicate, full, dequeued, empty), m_tdata the occupancy after the request
// and, on a dequeue, the removed key and data (zero otherwise).
// One request at a time, accept to next accept: an enqueue walks the held keys with one
// key-store read per cycle, then compares the last key and commits; on an empty queue it
// goes straight to commit. A dequeue reads the head from the stores, then commits; on an
// empty queue it goes straight to commit.
// The scan stops early at the first matching key.
// The result appears on the master side in the cycle after commit and waits in an output
// register; a stalled receiver holds the block in commit once the next result is ready.
// Reset clears the pointers, the count and the output valid; the stores are not cleared
// and are only read at entries that were written.
module unique_key_fifo_unit
    import ukf_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int OCC_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((OCC_W + KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // entry_key, entry_data, zero pad
    input  logic                s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // occupancy, removed_key, removed_data, zero pad
    output logic [STATUS_W-1:0] m_tuser    // status
);

    ukf_cmd_t  cmd;
    ukf_stat_t stat;

    ukf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    ukf_dpath #(
        .DEPTH      (DEPTH),
        .KEY_WIDTH  (KEY_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> verif/ukf_checker.sv
// Checker for the unique key FIFO: mirrors the queue and compares every result transaction.
module ukf_checker
    import ukf_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int OCC_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((OCC_W + KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,
    input  logic [STATUS_W-1:0] m_tuser,
    output int                  mismatch_count,
    output int                  results_awaited
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OCC_W-1:0]      occupancy;
        logic [KEY_WIDTH-1:0]  removed_key;
        logic [DATA_WIDTH-1:0] removed_data;
    } queue_result_t;

    logic [KEY_WIDTH-1:0]  key_ring [DEPTH];
    logic [DATA_WIDTH-1:0] data_ring [DEPTH];
    int                    head_slot = 0;
    int                    tail_slot = 0;
    int                    held_count = 0;
    queue_result_t         awaited_results [$];
    queue_result_t         want;

    initial
    begin
        mismatch_count  = 0;
        results_awaited = 0;
    end

    // Advance the mirrored queue by one request and return the result it must produce.
    function automatic queue_result_t queue_outcome(input logic req,
                                                    input logic [KEY_WIDTH-1:0] key,
                                                    input logic [DATA_WIDTH-1:0] data);
        queue_result_t res;
        bit            key_held;
        res      = '0;
        key_held = 1'b0;
        if (req == REQ_ENQUEUE)
        begin
            // only held entries take part in the duplicate check
            for (int i = 0; i < held_count; i++)
            begin
                if (key_ring[(head_slot + i) % DEPTH] == key)
                    key_held = 1'b1;
            end
            if (key_held)
                res.status = ST_DUPLICATE;
            else if (held_count >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                key_ring[tail_slot]  = key;
                data_ring[tail_slot] = data;
                tail_slot            = (tail_slot + 1) % DEPTH;
                held_count++;
                res.status = ST_ENQUEUED;
            end
        end
        else if (held_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.removed_key  = key_ring[head_slot];
            res.removed_data = data_ring[head_slot];
            head_slot        = (head_slot + 1) % DEPTH;
            held_count--;
            res.status = ST_DEQUEUED;
        end
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] wanted);
        $display("mismatch in %s: got %h, want %h at %0t", field, got, wanted, $time);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("unsolicited result", 64'(m_tdata), '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[OCC_W-1:0] !== want.occupancy)
                        report_mismatch("occupancy", 64'(m_tdata[OCC_W-1:0]),
                                        64'(want.occupancy));
                    if (m_tdata[OCC_W +: KEY_WIDTH] !== want.removed_key)
                        report_mismatch("removed_key", 64'(m_tdata[OCC_W +: KEY_WIDTH]),
                                        64'(want.removed_key));
                    if (m_tdata[OCC_W + KEY_WIDTH +: DATA_WIDTH] !== want.removed_data)
                        report_mismatch("removed_data",
                                        64'(m_tdata[OCC_W + KEY_WIDTH +: DATA_WIDTH]),
                                        64'(want.removed_data));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(queue_outcome(s_tuser, s_tdata[KEY_WIDTH-1:0],
                                                        s_tdata[KEY_WIDTH +: DATA_WIDTH]));
            results_awaited = awaited_results.size();
        end
    end

endmodule

>>> verif/tb.sv
// Testbench top for the unique key FIFO: clock, reset, request stimulus and the verdict.
module tb;
    import ukf_pkg::*;

    localparam int OCC_W = $clog2(DEPTH_DEF + 1);
    localparam int IN_W  = ((KEY_WIDTH_DEF + DATA_WIDTH_DEF + 7) / 8) * 8;
    localparam int OUT_W = ((OCC_W + KEY_WIDTH_DEF + DATA_WIDTH_DEF + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 1950;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                s_tuser = REQ_ENQUEUE;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    int                  mismatch_count;
    int                  results_awaited;
    bit                  steady = 1'b0;

    logic [31:0]         key_pool [20];
    logic [31:0]         edge_keys [16];
    logic [31:0]         pick_key;
    int                  enqueue_pct;

    unique_key_fifo_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ukf_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result channel at random outside the steady stretch.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 32);

    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(input logic req, input logic [31:0] key,
                                input logic [31:0] data);
        if (!steady && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {data, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Hold the request channel until every result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        // sample the checker's count away from the rising edge
        do
            @(negedge clk);
        while (results_awaited != 0);
        @(posedge clk);
    endtask

    initial
    begin
        edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
                      32'h0000_1000, 32'h0000_1001, 32'h0000_1002, 32'h0000_1003,
                      32'h0000_1004, 32'h0000_1005, 32'h0000_1006, 32'h0000_1007};
        foreach (key_pool[i])
            key_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // dequeue from an empty queue, then fill to the brim with extreme keys and data
        send_request(REQ_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (edge_keys[i])
            send_request(REQ_ENQUEUE, edge_keys[i],
                         (i % 2 == 0) ? ~edge_keys[i] : 32'h8000_0000 + i);
        send_request(REQ_ENQUEUE, 32'h1234_5678, 32'h7FFF_FFFF);
        // duplicate key into a full queue must report duplicate, not full
        send_request(REQ_ENQUEUE, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
        // a removed key is free again, a held one is not
        send_request(REQ_ENQUEUE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_ENQUEUE, 32'h7FFF_FFFF, 32'h0000_0000);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady = (n >= 600 && n < 900);
            case ((n / 150) % 3)
                0:       enqueue_pct = 70;
                1:       enqueue_pct = 50;
                default: enqueue_pct = 30;
            endcase
            pick_key = ($urandom_range(0, 99) < 55) ? key_pool[$urandom_range(0, 19)]
                                                    : $urandom;
            if (n == 1200)
                drain_results();
            if ($urandom_range(0, 99) < enqueue_pct)
                send_request(REQ_ENQUEUE, pick_key, $urandom);
            else
                send_request(REQ_DEQUEUE, $urandom, $urandom);
        end
        steady = 1'b0;

        drain_results();
        repeat (25) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ukf_pkg.sv
hw/rtl/ukf_ram.sv
hw/rtl/ukf_ctrl.sv
hw/rtl/ukf_dpath.sv
hw/rtl/unique_key_fifo_unit.sv
verif/ukf_checker.sv
verif/tb.sv
